// File: sv/mrdpec_pkg.sv
// Shared constants, codes and types for the readback deframer with PEC check.
// Used by mrdpec_core, mrdpec_outq and monitor_readback_deframer_pec.
`timescale 1ns / 1ps

package mrdpec_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned GroupW  = 2;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned SampleW = 12;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 5;
  localparam int unsigned PhaseW  = 2;

  localparam logic [ByteW-1:0] CrcPoly = 8'h07;

  localparam logic [PosW-1:0] LenConfig = 5'd7;
  localparam logic [PosW-1:0] LenCells  = 5'd19;
  localparam logic [PosW-1:0] LenTemps  = 5'd6;

  localparam logic [GroupW-1:0] GRP_CONFIG  = 2'd0;
  localparam logic [GroupW-1:0] GRP_CELLS   = 2'd1;
  localparam logic [GroupW-1:0] GRP_TEMPS   = 2'd2;
  localparam logic [GroupW-1:0] GRP_INVALID = 2'd3;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [StatusW-1:0] ST_PEC_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_PEC_BAD   = 2'd1;
  localparam logic [StatusW-1:0] ST_BAD_GROUP = 2'd2;

  localparam logic [PhaseW-1:0] PH_LOW  = 2'd0;
  localparam logic [PhaseW-1:0] PH_EVEN = 2'd1;
  localparam logic [PhaseW-1:0] PH_ODD  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [ChanW-1:0]   chan;
    logic [SampleW-1:0] value;
    logic [StatusW-1:0] status;
    logic               last;
  } result_t;

  // CRC-8, MSB first, no reflection, no final xor
  function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] data);
    logic [ByteW-1:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[ByteW-1]) begin
        v = {v[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[ByteW-2:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: sv/monitor_readback_deframer_pec.sv
// Top level of the readback deframer with PEC check.
// Depends on mrdpec_pkg, mrdpec_core and mrdpec_outq.
`timescale 1ns / 1ps

//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | sink      | in_valid_i / in_stall_o    | rx_byte_i, frame_group_i
//  out     | source    | out_valid_o / out_stall_i  | item_kind_o, channel_index_o,
//          |           |                            | sample_value_o, frame_status_o,
//          |           |                            | frame_last_o
//
// One byte per cycle while in_stall_o is low; a result passes through the input register
// and then the two-entry result queue before it is on the outputs.
// Reset clears the frame state to frame start and empties the queue.
// in_stall_o rises once the input register and the queue hold two items, not
// counting one that transfers out in the same cycle.

module monitor_readback_deframer_pec (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mrdpec_pkg::ByteW-1:0]        rx_byte_i,
  input  logic [mrdpec_pkg::GroupW-1:0]       frame_group_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                item_kind_o,
  output logic [mrdpec_pkg::ChanW-1:0]        channel_index_o,
  output logic [mrdpec_pkg::SampleW-1:0]      sample_value_o,
  output logic [mrdpec_pkg::StatusW-1:0]      frame_status_o,
  output logic                                frame_last_o
);

  logic                busy;
  logic                push;
  mrdpec_pkg::result_t res;
  mrdpec_pkg::result_t head;
  logic [1:0]          count;
  logic                pop;
  logic [2:0]          occ;
  logic                take;

  assign pop        = out_valid_o && !out_stall_i;
  assign occ        = {1'b0, count} + {2'b00, busy} - {2'b00, pop};
  assign in_stall_o = (occ >= 3'd2);
  assign take       = in_valid_i && !in_stall_o;

  mrdpec_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .rx_byte_i     (rx_byte_i),
    .frame_group_i (frame_group_i),
    .busy_o        (busy),
    .push_o        (push),
    .res_o         (res)
  );

  mrdpec_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (head),
    .count_o (count)
  );

  assign item_kind_o     = head.kind;
  assign channel_index_o = head.chan;
  assign sample_value_o  = head.value;
  assign frame_status_o  = head.status;
  assign frame_last_o    = head.last;

endmodule

// File: sv/mrdpec_core.sv
// Input register, frame state and per-byte decode: CRC update, 12-bit unpack,
// status generation. Depends on mrdpec_pkg.
`timescale 1ns / 1ps

module mrdpec_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic [mrdpec_pkg::ByteW-1:0]      rx_byte_i,
  input  logic [mrdpec_pkg::GroupW-1:0]     frame_group_i,
  output logic                              busy_o,
  output logic                              push_o,
  output mrdpec_pkg::result_t               res_o
);

  logic                            valid_q;
  logic [mrdpec_pkg::ByteW-1:0]    byte_q;
  logic [mrdpec_pkg::GroupW-1:0]   grp_q;

  logic [mrdpec_pkg::ByteW-1:0]    crc_q, crc_d;
  logic [mrdpec_pkg::PosW-1:0]     pos_q, pos_d;
  logic [mrdpec_pkg::GroupW-1:0]   held_q, held_d;
  logic [mrdpec_pkg::ByteW-1:0]    pend_q, pend_d;
  logic [mrdpec_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [mrdpec_pkg::ChanW-1:0]    chan_q, chan_d;

  logic                            first;
  logic [mrdpec_pkg::GroupW-1:0]   grp_eff;
  logic [mrdpec_pkg::ByteW-1:0]    crc_in;
  logic [mrdpec_pkg::PosW-1:0]     pos_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      byte_q <= rx_byte_i;
      grp_q  <= frame_group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      pos_q   <= '0;
      held_q  <= '0;
      pend_q  <= '0;
      phase_q <= mrdpec_pkg::PH_LOW;
      chan_q  <= '0;
    end else begin
      crc_q   <= crc_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      chan_q  <= chan_d;
    end
  end

  assign first   = (pos_q == '0);
  assign grp_eff = first ? grp_q : held_q;
  assign crc_in  = first ? '0 : crc_q;

  always_comb begin
    unique case (grp_eff)
      mrdpec_pkg::GRP_CELLS: pos_last = mrdpec_pkg::LenCells - 5'd1;
      mrdpec_pkg::GRP_TEMPS: pos_last = mrdpec_pkg::LenTemps - 5'd1;
      default:               pos_last = mrdpec_pkg::LenConfig - 5'd1;
    endcase
  end

  always_comb begin
    crc_d   = crc_q;
    pos_d   = pos_q;
    held_d  = held_q;
    pend_d  = pend_q;
    phase_d = phase_q;
    chan_d  = chan_q;
    push_o  = 1'b0;
    res_o   = '0;

    if (valid_q) begin
      if (first && (grp_q == mrdpec_pkg::GRP_INVALID)) begin
        // drop the byte, stay at frame start
        crc_d        = '0;
        push_o       = 1'b1;
        res_o.kind   = mrdpec_pkg::KIND_STATUS;
        res_o.status = mrdpec_pkg::ST_BAD_GROUP;
        res_o.last   = 1'b1;
      end else if (pos_q >= pos_last) begin
        crc_d        = '0;
        pos_d        = '0;
        held_d       = grp_eff;
        pend_d       = byte_q;
        phase_d      = mrdpec_pkg::PH_LOW;
        chan_d       = '0;
        push_o       = 1'b1;
        res_o.kind   = mrdpec_pkg::KIND_STATUS;
        res_o.status = (byte_q == crc_in) ? mrdpec_pkg::ST_PEC_OK : mrdpec_pkg::ST_PEC_BAD;
        res_o.last   = 1'b1;
      end else begin
        crc_d  = mrdpec_pkg::crc8_byte(crc_in, byte_q);
        pos_d  = pos_q + 5'd1;
        held_d = grp_eff;
        pend_d = byte_q;
        if (phase_q == mrdpec_pkg::PH_ODD) begin
          phase_d = mrdpec_pkg::PH_LOW;
          chan_d  = chan_q + 4'd2;
        end else begin
          phase_d = phase_q + 2'd1;
        end
        if (grp_eff == mrdpec_pkg::GRP_CONFIG) begin
          push_o      = 1'b1;
          res_o.kind  = mrdpec_pkg::KIND_VALUE;
          res_o.chan  = pos_q[mrdpec_pkg::ChanW-1:0];
          res_o.value = {4'h0, byte_q};
        end else begin
          unique case (phase_q)
            mrdpec_pkg::PH_EVEN: begin
              push_o      = 1'b1;
              res_o.kind  = mrdpec_pkg::KIND_VALUE;
              res_o.chan  = chan_q;
              res_o.value = {byte_q[3:0], pend_q};
            end
            mrdpec_pkg::PH_ODD: begin
              push_o      = 1'b1;
              res_o.kind  = mrdpec_pkg::KIND_VALUE;
              res_o.chan  = chan_q + 4'd1;
              res_o.value = {byte_q, pend_q[7:4]};
            end
            default: begin
              push_o = 1'b0;
            end
          endcase
        end
      end
    end
  end

  assign busy_o = valid_q;

endmodule

// File: sv/mrdpec_outq.sv
// Two-entry result queue in front of the output port.
// Depends on mrdpec_pkg.
`timescale 1ns / 1ps

module mrdpec_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mrdpec_pkg::result_t   data_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output mrdpec_pkg::result_t   data_o,
  output logic [1:0]            count_o
);

  mrdpec_pkg::result_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign do_pop  = pop_i && (count_q != 2'd0);
  assign count_d = count_q + {1'b0, push_i} - {1'b0, do_pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// File: bench/monitor_readback_deframer_pec_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for monitor_readback_deframer_pec: sends framed reply bytes,
// predicts every value and status item, and checks them under idle and stall patterns.
// Depends on mrdpec_pkg and the monitor_readback_deframer_pec RTL.

module monitor_readback_deframer_pec_tb;

  localparam int unsigned ByteW   = mrdpec_pkg::ByteW;
  localparam int unsigned GroupW  = mrdpec_pkg::GroupW;
  localparam int unsigned ChanW   = mrdpec_pkg::ChanW;
  localparam int unsigned SampleW = mrdpec_pkg::SampleW;
  localparam int unsigned StatusW = mrdpec_pkg::StatusW;
  localparam int unsigned PosW    = mrdpec_pkg::PosW;
  localparam int unsigned PhaseW  = mrdpec_pkg::PhaseW;

  localparam int unsigned HoldLen      = 120;
  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports   = 200;
  localparam int unsigned PhaseItems   = 450;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i     = '0;
  logic [GroupW-1:0]  frame_group_i = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               item_kind_o;
  logic [ChanW-1:0]   channel_index_o;
  logic [SampleW-1:0] sample_value_o;
  logic [StatusW-1:0] frame_status_o;
  logic               frame_last_o;

  logic [ByteW-1:0]     pec_acc   = '0;
  logic [PosW-1:0]      frame_pos = '0;
  logic [GroupW-1:0]    frame_grp = '0;
  logic [ByteW-1:0]     prev_byte = '0;
  mrdpec_pkg::result_t  due_items[$];

  idle_mode_e  idle_mode    = IDLE_NONE;
  int unsigned error_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned hold_seq     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned stuck_cycles = 0;

  monitor_readback_deframer_pec u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_group_i   (frame_group_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_kind_o     (item_kind_o),
    .channel_index_o (channel_index_o),
    .sample_value_o  (sample_value_o),
    .frame_status_o  (frame_status_o),
    .frame_last_o    (frame_last_o)
  );

  always #5 clk_i = ~clk_i;

  // bitwise CRC-8, poly 0x07, MSB first
  function automatic logic [ByteW-1:0] pec_update(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] data);
    logic [ByteW-1:0] r;
    logic             fb;
    r = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = r[ByteW-1] ^ data[i];
      r  = {r[ByteW-2:0], 1'b0};
      if (fb) begin
        r = r ^ mrdpec_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic int unsigned group_len(input logic [GroupW-1:0] g);
    case (g)
      mrdpec_pkg::GRP_CELLS: begin
        return mrdpec_pkg::LenCells;
      end
      mrdpec_pkg::GRP_TEMPS: begin
        return mrdpec_pkg::LenTemps;
      end
      default: begin
        return mrdpec_pkg::LenConfig;
      end
    endcase
  endfunction

  function automatic logic [ByteW-1:0] rand_byte();
    case ($urandom_range(9))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      default: begin
        return ByteW'($urandom_range(255));
      end
    endcase
  endfunction

  function void deframe_predict(input logic [ByteW-1:0] b, input logic [GroupW-1:0] g);
    mrdpec_pkg::result_t r;
    logic [PhaseW-1:0]   phase;
    logic [ChanW-1:0]    pair;
    r = '0;
    if (frame_pos == '0) begin
      if (g == mrdpec_pkg::GRP_INVALID) begin
        pec_acc  = '0;
        r.kind   = mrdpec_pkg::KIND_STATUS;
        r.status = mrdpec_pkg::ST_BAD_GROUP;
        r.last   = 1'b1;
        due_items.push_back(r);
        return;
      end
      frame_grp = g;
      pec_acc   = '0;
    end
    if (frame_pos >= group_len(frame_grp) - 1) begin
      r.kind    = mrdpec_pkg::KIND_STATUS;
      r.status  = (b == pec_acc) ? mrdpec_pkg::ST_PEC_OK : mrdpec_pkg::ST_PEC_BAD;
      r.last    = 1'b1;
      due_items.push_back(r);
      pec_acc   = '0;
      frame_pos = '0;
      prev_byte = b;
      return;
    end
    pec_acc = pec_update(pec_acc, b);
    if (frame_grp == mrdpec_pkg::GRP_CONFIG) begin
      r.kind  = mrdpec_pkg::KIND_VALUE;
      r.chan  = frame_pos[ChanW-1:0];
      r.value = {4'h0, b};
      due_items.push_back(r);
    end else begin
      phase = PhaseW'(frame_pos % 3);
      pair  = ChanW'((frame_pos / 3) * 2);
      case (phase)
        mrdpec_pkg::PH_EVEN: begin
          r.kind  = mrdpec_pkg::KIND_VALUE;
          r.chan  = pair;
          r.value = {b[3:0], prev_byte};
          due_items.push_back(r);
        end
        mrdpec_pkg::PH_ODD: begin
          r.kind  = mrdpec_pkg::KIND_VALUE;
          r.chan  = pair + ChanW'(1);
          r.value = {b, prev_byte[7:4]};
          due_items.push_back(r);
        end
        default: begin
        end
      endcase
    end
    prev_byte = b;
    frame_pos = frame_pos + PosW'(1);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic [GroupW-1:0] g);
    int unsigned pct;
    pct = (idle_mode == IDLE_SEND) ? 62 : (idle_mode == IDLE_BOTH) ? 20 : 0;
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    rx_byte_i     <= b;
    frame_group_i <= g;
    do @(posedge clk_i); while (in_stall_o);
    deframe_predict(b, g);
    bytes_sent++;
  endtask

  task automatic quiet_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    quiet_input();
    while (due_items.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // starts at frame start; group on later bytes is don't-care
  task automatic send_frame(input logic [GroupW-1:0] g, input bit good_pec, input bit extremes);
    logic [ByteW-1:0]  crc;
    logic [ByteW-1:0]  b;
    logic [GroupW-1:0] gsel;
    int unsigned       n;
    n   = group_len(g);
    crc = '0;
    for (int i = 0; i < n - 1; i++) begin
      if (extremes) begin
        b = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
        b = rand_byte();
      end
      crc  = pec_update(crc, b);
      gsel = (i == 0) ? g : GroupW'($urandom_range(3));
      send_byte(b, gsel);
    end
    b = good_pec ? crc : crc ^ ByteW'($urandom_range(1, 255));
    send_byte(b, GroupW'($urandom_range(3)));
  endtask

  task automatic resync();
    while (frame_pos != '0) begin
      send_byte(rand_byte(), GroupW'($urandom_range(3)));
    end
  endtask

  task automatic send_random_traffic(input int unsigned items);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_byte(rand_byte(), mrdpec_pkg::GRP_INVALID);
      end else if (pick < 12) begin
        repeat ($urandom_range(1, 8)) send_byte(rand_byte(), GroupW'($urandom_range(3)));
        resync();
      end else begin
        send_frame(GroupW'($urandom_range(2)), $urandom_range(99) < 80, 1'b0);
      end
    end
  endtask

  task automatic test_directed_frames();
    idle_mode = IDLE_NONE;
    send_byte(8'hFF, mrdpec_pkg::GRP_INVALID);
    send_frame(mrdpec_pkg::GRP_CONFIG, 1'b1, 1'b1);
    send_frame(mrdpec_pkg::GRP_TEMPS, 1'b0, 1'b1);
    send_frame(mrdpec_pkg::GRP_CELLS, 1'b1, 1'b1);
    send_byte(8'h00, mrdpec_pkg::GRP_INVALID);
    wait_drain();
  endtask

  task automatic test_random_phase(input idle_mode_e mode);
    idle_mode = mode;
    send_random_traffic(PhaseItems);
    wait_drain();
  endtask

  task automatic test_output_holdoff();
    idle_mode = IDLE_NONE;
    hold_seq++;
    send_frame(mrdpec_pkg::GRP_CELLS, 1'b1, 1'b0);
    send_frame(mrdpec_pkg::GRP_CELLS, 1'b0, 1'b0);
    wait_drain();
  endtask

  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= HoldLen;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall_i <= ($urandom_range(99) < 62);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall_i <= ($urandom_range(99) < 20);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    mrdpec_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_items.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("%0t: unexpected transfer, expected none, got kind %0d chan %0d value %0d",
                   $time, item_kind_o, channel_index_o, sample_value_o);
        end
      end else begin
        want = due_items.pop_front();
        check_field("item_kind", want.kind, item_kind_o);
        check_field("channel_index", want.chan, channel_index_o);
        check_field("sample_value", want.value, sample_value_o);
        check_field("frame_status", want.status, frame_status_o);
        check_field("frame_last", want.last, frame_last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("monitor_readback_deframer_pec_tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_frames();
    test_random_phase(IDLE_NONE);
    test_random_phase(IDLE_SEND);
    test_output_holdoff();
    test_random_phase(IDLE_RECV);
    test_random_phase(IDLE_BOTH);
    if (error_count == 0 && due_items.size() == 0) begin
      $display("monitor_readback_deframer_pec_tb: done, clean");
    end else begin
      $display("monitor_readback_deframer_pec_tb: done, errors");
    end
    $finish;
  end

endmodule
